// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg
// Shared constants and types of the insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

    localparam int SORT_DEPTH = 64;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = $clog2(SORT_DEPTH + 1);

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_count;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the new key this cycle
        logic drain;  // shift all keys one cell toward the head
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/isort_cell.sv =====
// ----------------------------------------------------------------------------
// isort_cell
// One cell of the sorting chain: holds one key, opens a gap on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_cell (
    input  wire logic                  i_clk,
    input  wire isort_pkg::t_cell_ctrl i_ctrl,
    input  wire isort_pkg::t_key       i_new_key,
    input  wire logic                  i_occupied,
    input  wire isort_pkg::t_key       i_prev_key,
    input  wire logic                  i_prev_gt,
    input  wire isort_pkg::t_key       i_next_key,
    output      isort_pkg::t_key       o_key,
    output      logic                  o_gt
);

    isort_pkg::t_key r_key;
    isort_pkg::t_key n_key;

    // An empty cell ranks above every key.
    assign o_gt = !i_occupied || (r_key > i_new_key);

    always_comb begin
        n_key = r_key;
        if (i_ctrl.drain) begin
            n_key = i_next_key;
        end else if (i_ctrl.load && o_gt) begin
            // take the neighbor's key if it moves too, else the new key lands here
            n_key = i_prev_gt ? i_prev_key : i_new_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

// ===== rtl/core/insertion_sorter.sv =====
// A key is inserted at the edge that accepts it; once the final word of a set
//   is accepted the FSM enters drain and the head cell's key is registered out.
// Throughput: one key per cycle while loading; the stored keys of a set then
//   drain one word per cycle, with busy high and no key taken until all are out.
// Reset: synchronous, active low; clears the key count, drop flag and FSM.
// The receiver cannot stall: each result word shows for exactly one cycle.
// ----------------------------------------------------------------------------
// insertion_sorter
// Sorts a set of signed Q16.16 keys in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module insertion_sorter (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output      logic            busy,
    input  wire isort_pkg::t_key i_key_value,
    input  wire logic            i_set_end,
    output      logic            o_strobe,
    output      isort_pkg::t_key o_sorted_value,
    output      logic            o_run_end,
    output      logic            o_keys_dropped
);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    localparam int DEPTH = isort_pkg::SORT_DEPTH;

    t_state                r_state;
    isort_pkg::t_count     r_count;
    isort_pkg::t_count     r_remain;
    logic                  r_overflow;
    logic                  r_strobe;
    isort_pkg::t_key       r_value;
    logic                  r_run_end;
    logic                  r_dropped;

    logic                  accept;
    logic                  full;
    isort_pkg::t_cell_ctrl cell_ctrl;
    isort_pkg::t_key       cell_key [DEPTH];
    logic                  cell_gt  [DEPTH];
    logic                  cell_occ [DEPTH];

    assign busy   = (r_state == ST_DRAIN);
    assign accept = start && !busy;
    assign full   = (r_count == isort_pkg::t_count'(DEPTH));

    // Insert only while room is left; drain shifts the whole chain toward cell 0.
    assign cell_ctrl.load  = accept && !full;
    assign cell_ctrl.drain = busy;

    // ------------------------------------------------------------------------
    // Cell chain: cell i holds the i-th smallest key; cells at or above the
    // count are empty and take part as "greater than anything".
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        isort_pkg::t_key prev_key;
        logic            prev_gt;
        isort_pkg::t_key next_key;

        assign cell_occ[g] = (r_count > isort_pkg::t_count'(g));

        if (g == 0) begin : g_head
            assign prev_key = i_key_value;
            assign prev_gt  = 1'b0;
        end else begin : g_body
            assign prev_key = cell_key[g-1];
            assign prev_gt  = cell_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_key = cell_key[g];
        end else begin : g_mid
            assign next_key = cell_key[g+1];
        end

        isort_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_new_key  (i_key_value),
            .i_occupied (cell_occ[g]),
            .i_prev_key (prev_key),
            .i_prev_gt  (prev_gt),
            .i_next_key (next_key),
            .o_key      (cell_key[g]),
            .o_gt       (cell_gt[g])
        );
    end

    // ------------------------------------------------------------------------
    // Control: count keys, hold the sticky drop flag, and stream the set out
    // from the head cell once the final word arrives.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_value   <= cell_key[0];
        r_run_end <= (r_remain == isort_pkg::t_count'(1));
        r_dropped <= r_overflow;
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_remain   <= '0;
            r_overflow <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= busy;
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (full) begin
                            r_overflow <= 1'b1;
                        end else begin
                            r_count <= r_count + isort_pkg::t_count'(1);
                        end
                        if (i_set_end) begin
                            // the set is never empty here: the key is stored or the store is full
                            r_remain <= full ? r_count : r_count + isort_pkg::t_count'(1);
                            r_state  <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    r_remain <= r_remain - isort_pkg::t_count'(1);
                    if (r_remain == isort_pkg::t_count'(1)) begin
                        // last word leaves: clear the set
                        r_count    <= '0;
                        r_overflow <= 1'b0;
                        r_state    <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_sorted_value = r_value;
    assign o_run_end      = r_strobe && r_run_end;
    assign o_keys_dropped = r_dropped;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= isort_pkg::t_count'(DEPTH))
    `ASSERT_IMPLIES(a_drain_nonzero, i_clk, i_rst_n, busy, r_remain != '0 && r_remain <= r_count)
    `ASSERT_NEXT(a_final_starts_drain, i_clk, i_rst_n, accept && i_set_end, busy)
    `ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, busy && r_remain == isort_pkg::t_count'(1), !busy && o_run_end)
    `ASSERT_NEXT(a_gap_after_run, i_clk, i_rst_n, o_strobe && o_run_end, !o_strobe)

endmodule

`default_nettype wire

// ===== dv/tb_insertion_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_insertion_sorter
// Self-checking bench for the insertion sorter. Sets of signed keys go in one
// word per handshake; a scoreboard keeps its own sorted copy of each set and
// checks every output word, field by field, in the order it must arrive.
// ----------------------------------------------------------------------------

// Scoreboard: sort each incoming set the same way the block must, and hold
// the words the block owes us until they show up on the output.
class sorted_run_model;

    typedef struct {
        isort_pkg::t_key value;
        logic            run_end;
        logic            dropped;
    } t_sorted_word;

    isort_pkg::t_key key_store [isort_pkg::SORT_DEPTH];
    int              held;
    bit              overflow;
    t_sorted_word    owed_words [$];
    int              mismatches;

    function new();
        held       = 0;
        overflow   = 0;
        mismatches = 0;
    endfunction

    // Insert an accepted key behind any equal keys; on the set's last key,
    // queue the whole set in ascending order and clear for the next set.
    function void note_key(isort_pkg::t_key key, logic last);
        int           pos;
        t_sorted_word w;
        if (held < isort_pkg::SORT_DEPTH) begin
            pos = held;
            while (pos > 0 && key_store[pos-1] > key) begin
                key_store[pos] = key_store[pos-1];
                pos--;
            end
            key_store[pos] = key;
            held++;
        end else begin
            overflow = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < held; i++) begin
                w.value   = key_store[i];
                w.run_end = (i == held - 1);
                w.dropped = overflow;
                owed_words.push_back(w);
            end
            held     = 0;
            overflow = 1'b0;
        end
    endfunction

    function void check_word(isort_pkg::t_key value, logic run_end, logic dropped);
        t_sorted_word w;
        if (owed_words.size() == 0) begin
            $error("unexpected output word: sorted_value %0d", value);
            mismatches++;
            return;
        end
        w = owed_words.pop_front();
        if (value !== w.value) begin
            $error("sorted_value: expected %0d, got %0d", w.value, value);
            mismatches++;
        end
        if (run_end !== w.run_end) begin
            $error("run_end: expected %0b, got %0b", w.run_end, run_end);
            mismatches++;
        end
        if (dropped !== w.dropped) begin
            $error("keys_dropped: expected %0b, got %0b", w.dropped, dropped);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return owed_words.size();
    endfunction

endclass

module tb_insertion_sorter;

    import isort_pkg::*;

    // Cycles with neither an accepted key nor an output word before we give up.
    localparam int IDLE_LIMIT  = 2000;
    // Random keys to push after the directed sets.
    localparam int RANDOM_KEYS = 300;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic start       = 1'b0;
    logic i_set_end   = 1'b0;
    t_key i_key_value = '0;
    logic busy;
    logic o_strobe;
    t_key o_sorted_value;
    logic o_run_end;
    logic o_keys_dropped;

    sorted_run_model sorter_model;
    int              idle_cycles = 0;
    int              random_sent = 0;
    t_key            last_key    = '0;

    always #5 i_clk = ~i_clk;

    insertion_sorter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_key_value    (i_key_value),
        .i_set_end      (i_set_end),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_run_end      (o_run_end),
        .o_keys_dropped (o_keys_dropped)
    );

    // Monitor: sample both sides at the rising edge, before the block's own
    // updates land. Note accepted keys first, then check any output word;
    // a set's words never come out on the edge that takes its last key.
    // The watchdog rides along and resets on any activity.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sorter_model.note_key(i_key_value, i_set_end);
            if (o_strobe)
                sorter_model.check_word(o_sorted_value, o_run_end, o_keys_dropped);
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Mix full-range keys with a narrow band around zero and repeats, so
    // equal keys show up often enough to exercise stable ordering.
    function automatic t_key pick_key();
        case ($urandom_range(0, 9))
            6, 7:    return t_key'($signed($urandom_range(0, 8)) - 4);
            8:       return $urandom_range(0, 1) ? t_key'(32'h8000_0000)
                                                 : t_key'(32'h7FFF_FFFF);
            9:       return last_key;
            default: return t_key'($urandom);
        endcase
    endfunction

    // Present one word at the falling edge and hold it until the block takes
    // it. Leave start high on return so the next word can follow at once.
    task automatic send_key(input t_key key, input logic last);
        i_key_value = key;
        i_set_end   = last;
        start       = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        last_key = key;
    endtask

    // Drop start for a random number of cycles, if any.
    task automatic idle_gap();
        int n;
        n = gap_len();
        if (n > 0) begin
            start = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Hold off the sender until every owed word has come out.
    task automatic wait_drained();
        start = 1'b0;
        while (sorter_model.outstanding() != 0) @(negedge i_clk);
    endtask

    // Send one set of random keys; a burst set never idles between words.
    task automatic send_set(input int n, input bit burst);
        for (int i = 0; i < n; i++) begin
            send_key(pick_key(), i == n - 1);
            random_sent++;
            if (!burst)
                idle_gap();
        end
        if (!burst)
            start = 1'b0;
    endtask

    // Send a fixed list as one set, ending it on the last entry.
    task automatic send_list(input t_key keys [$]);
        foreach (keys[i]) begin
            send_key(keys[i], i == keys.size() - 1);
            idle_gap();
        end
        start = 1'b0;
    endtask

    initial begin
        int  n;
        bit  burst;
        sorter_model = new();

        // Hold reset low, then release it at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: a one-key set at the top of the range.
        send_list('{t_key'(32'h7FFF_FFFF)});
        // Both extremes, zero, +/-1 LSB, -1.0, a duplicate, and a last key
        // equal to the minimum so it must land behind the first one.
        send_list('{t_key'(32'h0000_0000), t_key'(32'h7FFF_FFFF),
                    t_key'(32'h8000_0000), t_key'(32'hFFFF_FFFF),
                    t_key'(32'h0000_0001), t_key'(32'h0001_0000),
                    t_key'(32'h0001_0000), t_key'(32'hFFFF_0000),
                    t_key'(32'h8000_0000)});
        // Already ascending, then strictly descending input.
        send_list('{t_key'(-3), t_key'(-2), t_key'(-1), t_key'(5)});
        send_list('{t_key'(40), t_key'(30), t_key'(20), t_key'(10)});

        // Let the sorter empty out completely before the random part.
        wait_drained();

        // Fill the store exactly, then overfill it so the last key is the
        // one that gets dropped and the set still has to come out.
        send_set(SORT_DEPTH, 1'b0);
        send_set(SORT_DEPTH + 1, 1'b0);

        // Random sets: mostly small, some mid-sized, a few near, at or past depth.
        while (random_sent < RANDOM_KEYS) begin
            case ($urandom_range(0, 19))
                0:       n = SORT_DEPTH + $urandom_range(0, 3);
                1:       n = $urandom_range(SORT_DEPTH - 2, SORT_DEPTH);
                2, 3, 4: n = $urandom_range(13, 40);
                default: n = $urandom_range(1, 12);
            endcase
            burst = ($urandom_range(0, 3) == 0);
            send_set(n, burst);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            else if (!burst)
                idle_gap();
        end

        // Stop sending, collect the last words, then keep watching the output
        // to catch anything the block emits without being owed.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sorter_model.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
